@@ hdl/osc_pkg.sv @@
// ----------------------------------------------------------------------------
// osc_pkg
// Shared types and constants of the OSC message parser: word formats,
// item kinds, status codes and tag characters.
// ----------------------------------------------------------------------------
`default_nettype none

package osc_pkg;

	localparam int MAX_TAGS = 16;
	// tag count and argument index hold 0 .. MAX_TAGS
	localparam int CNT_W    = $clog2(MAX_TAGS + 1);
	localparam int IDX_W    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int ARG_W    = 5;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [2:0] KIND_ADDR   = 3'd0;
	localparam logic [2:0] KIND_STR    = 3'd1;
	localparam logic [2:0] KIND_INT    = 3'd2;
	localparam logic [2:0] KIND_FLOAT  = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_BAD_HEAD  = 3'd2;
	localparam logic [2:0] ST_TRUNC     = 3'd3;
	localparam logic [2:0] ST_UNKNOWN   = 3'd4;
	localparam logic [2:0] ST_TOO_MANY  = 3'd5;

	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_F     = 8'h66;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]       item_kind;
		logic [31:0]      item_value;
		logic [ARG_W-1:0] arg_number;
		logic             string_end;
		logic [2:0]       status_code;
		logic             message_end;
	} out_t;

	// one queue entry: an optional data item, then an optional status item
	typedef struct packed {
		logic             has_data;
		logic [2:0]       kind;
		logic [31:0]      value;
		logic [ARG_W-1:0] arg;
		logic             str_end;
		logic             has_status;
		logic [2:0]       status;
	} rec_t;

endpackage

`default_nettype wire

@@ hdl/osc_front.sv @@
// ----------------------------------------------------------------------------
// osc_front
// Byte classifier: walks address, type tags and arguments, one byte per
// cycle while the queue has room; pushes the resulting data and status items.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_front import osc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic byte_valid,
	output logic      byte_ready,
	input  wire in_t  byte_data,
	input  wire logic q_full,
	output logic      push,
	output rec_t      rec
);

	typedef enum logic [5:0] {
		PH_ADDR     = 6'b000001,
		PH_TAG_HEAD = 6'b000010,
		PH_TAG_BODY = 6'b000100,
		PH_ARG      = 6'b001000,
		PH_DONE     = 6'b010000,
		PH_FAIL     = 6'b100000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [1:0]       biw_q, biw_d;
	logic             term_q, term_d;
	logic             seen_q, seen_d;
	logic [CNT_W-1:0] tag_count_q, tag_count_d;
	logic [CNT_W-1:0] cur_arg_q, cur_arg_d;
	logic [31:0]      word_q, word_d;
	logic [2:0]       err_q, err_d;
	logic             bad_seen_q, bad_seen_d;
	logic [CNT_W-1:0] bad_idx_q, bad_idx_d;
	logic [7:0]       tag_store_q [MAX_TAGS];
	logic [7:0]       cur_tag_q;

	logic             accept;
	logic             tag_we;
	logic             start_arg;
	logic [CNT_W-1:0] start_idx;
	logic [7:0]       b;

	assign b          = byte_data.data_byte;
	assign byte_ready = !q_full;
	assign accept     = byte_valid && !q_full;

	always_comb begin
		phase_d     = phase_q;
		biw_d       = biw_q;
		term_d      = term_q;
		seen_d      = seen_q;
		tag_count_d = tag_count_q;
		cur_arg_d   = cur_arg_q;
		word_d      = word_q;
		err_d       = err_q;
		bad_seen_d  = bad_seen_q;
		bad_idx_d   = bad_idx_q;
		tag_we      = 1'b0;
		start_arg   = 1'b0;
		start_idx   = '0;
		rec         = '0;

		if (phase_q != PH_DONE && phase_q != PH_FAIL) begin
			biw_d = biw_q + 2'd1;
		end

		case (phase_q)
			PH_ADDR: begin
				if (!term_q) begin
					if (b != 8'd0) begin
						rec.has_data = 1'b1;
						rec.kind     = KIND_ADDR;
						rec.value    = {24'd0, b};
						seen_d       = 1'b1;
					end else if (!seen_q) begin
						phase_d = PH_FAIL;
						err_d   = ST_EMPTY;
					end else begin
						term_d       = 1'b1;
						rec.has_data = 1'b1;
						rec.kind     = KIND_ADDR;
						rec.str_end  = 1'b1;
					end
				end
				if (phase_d != PH_FAIL && term_d && biw_d == 2'd0) begin
					term_d  = 1'b0;
					phase_d = PH_TAG_HEAD;
				end
			end
			PH_TAG_HEAD: begin
				if (b == CH_COMMA) begin
					phase_d = PH_TAG_BODY;
				end else begin
					phase_d = PH_FAIL;
					err_d   = ST_BAD_HEAD;
				end
			end
			PH_TAG_BODY: begin
				if (!term_q) begin
					if (b != 8'd0) begin
						if (tag_count_q >= CNT_W'(MAX_TAGS)) begin
							phase_d = PH_FAIL;
							err_d   = ST_TOO_MANY;
						end else begin
							tag_we      = 1'b1;
							tag_count_d = tag_count_q + 1'b1;
							// note the first tag that cannot start an argument
							if (b != CH_S && b != CH_I && b != CH_F && !bad_seen_q) begin
								bad_seen_d = 1'b1;
								bad_idx_d  = tag_count_q;
							end
						end
					end else begin
						term_d = 1'b1;
					end
				end
				if (phase_d != PH_FAIL && term_d && biw_d == 2'd0) begin
					start_arg = 1'b1;
					start_idx = '0;
				end
			end
			PH_ARG: begin
				if (cur_tag_q == CH_S) begin
					if (!term_q) begin
						rec.has_data = 1'b1;
						rec.kind     = KIND_STR;
						rec.value    = {24'd0, b};
						rec.arg      = ARG_W'(cur_arg_q);
						if (b == 8'd0) begin
							term_d      = 1'b1;
							rec.str_end = 1'b1;
						end
					end
					if (term_d && biw_d == 2'd0) begin
						start_arg = 1'b1;
						start_idx = cur_arg_q + 1'b1;
					end
				end else begin
					word_d = {word_q[23:0], b};
					if (biw_d == 2'd0) begin
						rec.has_data = 1'b1;
						rec.kind     = (cur_tag_q == CH_I) ? KIND_INT : KIND_FLOAT;
						rec.value    = word_d;
						rec.arg      = ARG_W'(cur_arg_q);
						start_arg    = 1'b1;
						start_idx    = cur_arg_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (start_arg) begin
			term_d    = 1'b0;
			word_d    = '0;
			cur_arg_d = start_idx;
			if (start_idx >= tag_count_q) begin
				phase_d = PH_DONE;
			end else if (bad_seen_q && bad_idx_q == start_idx) begin
				phase_d = PH_FAIL;
				err_d   = ST_UNKNOWN;
			end else begin
				phase_d = PH_ARG;
			end
		end

		rec.has_status = byte_data.last_byte;
		if (phase_d == PH_DONE) begin
			rec.status = ST_OK;
		end else if (phase_d == PH_FAIL) begin
			rec.status = err_d;
		end else begin
			rec.status = ST_TRUNC;
		end
	end

	assign push = accept && (rec.has_data || rec.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ADDR;
			biw_q       <= '0;
			term_q      <= 1'b0;
			seen_q      <= 1'b0;
			tag_count_q <= '0;
			cur_arg_q   <= '0;
			word_q      <= '0;
			err_q       <= '0;
			bad_seen_q  <= 1'b0;
			bad_idx_q   <= '0;
		end else if (accept) begin
			if (byte_data.last_byte) begin
				// final byte: back to the start of a message
				phase_q     <= PH_ADDR;
				biw_q       <= '0;
				term_q      <= 1'b0;
				seen_q      <= 1'b0;
				tag_count_q <= '0;
				cur_arg_q   <= '0;
				word_q      <= '0;
				err_q       <= '0;
				bad_seen_q  <= 1'b0;
				bad_idx_q   <= '0;
			end else begin
				phase_q     <= phase_d;
				biw_q       <= biw_d;
				term_q      <= term_d;
				seen_q      <= seen_d;
				tag_count_q <= tag_count_d;
				cur_arg_q   <= cur_arg_d;
				word_q      <= word_d;
				err_q       <= err_d;
				bad_seen_q  <= bad_seen_d;
				bad_idx_q   <= bad_idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && tag_we) begin
			tag_store_q[tag_count_q[IDX_W-1:0]] <= b;
		end
		// fetch the tag of the argument about to start
		if (accept && start_arg) begin
			cur_tag_q <= tag_store_q[start_idx[IDX_W-1:0]];
		end
	end

endmodule

`default_nettype wire

@@ hdl/osc_queue.sv @@
// ----------------------------------------------------------------------------
// osc_queue
// Short FIFO of item records between the byte classifier and the output
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_queue import osc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t wr_rec,
	output logic      full,
	output logic      head_valid,
	output rec_t      head,
	input  wire logic pop
);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

`default_nettype wire

@@ hdl/osc_back.sv @@
// ----------------------------------------------------------------------------
// osc_back
// Output stage: splits each record into its data and status items and
// holds them in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_back import osc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire rec_t head,
	output logic      pop,
	output logic      item_valid,
	input  wire logic item_ready,
	output out_t      item_data
);

	logic out_valid_q;
	out_t out_q;
	logic sub_q;
	logic load;
	logic send_data;

	assign load       = head_valid && (!out_valid_q || item_ready);
	assign send_data  = head.has_data && !sub_q;
	// retire the record once its last item is loaded
	assign pop        = load && !(send_data && head.has_status);
	assign item_valid = out_valid_q;
	assign item_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sub_q       <= send_data && head.has_status;
			end else if (item_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_data) begin
				out_q.item_kind   <= head.kind;
				out_q.item_value  <= head.value;
				out_q.arg_number  <= head.arg;
				out_q.string_end  <= head.str_end;
				out_q.status_code <= ST_OK;
				out_q.message_end <= 1'b0;
			end else begin
				out_q.item_kind   <= KIND_STATUS;
				out_q.item_value  <= '0;
				out_q.arg_number  <= '0;
				out_q.string_end  <= 1'b0;
				out_q.status_code <= head.status;
				out_q.message_end <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/osc_message_parser.sv @@
// ----------------------------------------------------------------------------
// osc_message_parser
// OSC message parser: address, type tags and s/i/f arguments from a byte
// stream, with a status item at the end of every message.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  byte    | in        | byte_valid/byte_ready  | in_t  (data_byte, last_byte)
//  item    | out       | item_valid/item_ready  | out_t (kind, value, arg, ...)
//
// One byte is accepted every cycle when not stalled; the classifier updates
// its phase in the accepting cycle and queues at most one record per byte.
// A final byte that also closes data yields two items; the four-entry
// queue absorbs this.
// Input stalls only when the queue is full; output stalls back up through it.
// Asynchronous reset clears all control state; the tag store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_message_parser import osc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic byte_valid,
	output logic      byte_ready,
	input  wire in_t  byte_data,
	output logic      item_valid,
	input  wire logic item_ready,
	output out_t      item_data
);

	logic push;
	rec_t wr_rec;
	logic q_full;
	logic head_valid;
	rec_t head;
	logic pop;

	osc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.q_full    (q_full),
		.push      (push),
		.rec       (wr_rec)
	);

	osc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (wr_rec),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	osc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_data (item_data)
	);

endmodule

`default_nettype wire

@@ hdl/osc_checker.sv @@
// ----------------------------------------------------------------------------
// osc_checker
// Port-level checks of the OSC message parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_checker import osc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_valid,
	input wire logic byte_ready,
	input wire in_t  byte_data,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire out_t item_data
);

	// hold an input word that waits
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
		else $error("input word changed while waiting");

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item_data))
		else $error("output word changed while stalled");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_data.item_kind == KIND_STATUS |->
			item_data.message_end && item_data.item_value == 32'd0 &&
			item_data.arg_number == '0 && !item_data.string_end)
		else $error("malformed status item");

	a_data_form: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_data.item_kind != KIND_STATUS |->
			!item_data.message_end && item_data.status_code == ST_OK)
		else $error("data item carries status fields");

	a_str_end: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_data.string_end |->
			(item_data.item_kind == KIND_ADDR || item_data.item_kind == KIND_STR) &&
			item_data.item_value == 32'd0)
		else $error("string end on a non-terminator item");

endmodule

bind osc_message_parser osc_checker u_osc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.byte_valid(byte_valid),
	.byte_ready(byte_ready),
	.byte_data (byte_data),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.item_data (item_data)
);

`default_nettype wire
